// File: rtl/mono_mix_level_meter_unit_assert.svh
// Assertion macros shared by the mono mix level meter RTL
`ifndef MONO_MIX_LEVEL_METER_UNIT_ASSERT_SVH
`define MONO_MIX_LEVEL_METER_UNIT_ASSERT_SVH

// check on every clock edge outside reset
`define MMLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define MMLM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mmlm_pkg.sv
// Shared constants and types of the mono mix level meter
package mmlm_pkg;

    localparam int MAX_CHANNELS   = 8;
    localparam int MAX_BLOCK      = 4096;
    localparam int SAMPLE_BITS    = 16;

    localparam int CFG_BITS       = 4;
    localparam int SUM_BITS       = SAMPLE_BITS + $clog2(MAX_CHANNELS);
    localparam int MIX_STEP_BITS  = $clog2(SUM_BITS);
    localparam int MAG_BITS       = SAMPLE_BITS;
    localparam int SQ_STEP_BITS   = $clog2(MAG_BITS);
    localparam int ADDEND_BITS    = 2 * MAG_BITS;
    localparam int TALLY_BITS     = $clog2(MAX_BLOCK) + 1;
    localparam int SQ_SUM_BITS    = ADDEND_BITS - 2 + TALLY_BITS - 1 + 1;
    localparam int DIV_STEP_BITS  = $clog2(SQ_SUM_BITS);
    localparam int MEAN_BITS      = ADDEND_BITS;
    localparam int ROOT_BITS      = MEAN_BITS / 2;
    localparam int ROOT_STEP_BITS = $clog2(ROOT_BITS);
    localparam int ROOT_REM_BITS  = ROOT_BITS + 4;

    localparam logic [CFG_BITS-1:0] CH_RESET = CFG_BITS'(1);

    typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;

    typedef struct packed {
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] mono;
        logic [MAG_BITS-1:0]           mag;
    } mix_stat_t;

    typedef struct packed {
        logic                 done;
        logic [MEAN_BITS-1:0] quotient;
    } div_stat_t;

    typedef struct packed {
        logic                 done;
        logic [ROOT_BITS-1:0] root;
    } sqrt_stat_t;

endpackage

// File: rtl/mmlm_mix.sv
// Channel-serial downmix with a bit-serial divide by the channel count
module mmlm_mix
    import mmlm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  frame_t              frame,
    input  logic [CFG_BITS-1:0] channel_count,
    output mix_stat_t           stat
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_ACC,
        M_DIV
    } mix_state_t;

    mix_state_t                   state_reg;
    frame_t                       frame_sh_reg;
    logic [CFG_BITS-1:0]          left_reg;
    logic [CFG_BITS-1:0]          n_reg;
    logic signed [SUM_BITS-1:0]   sum_reg;
    logic                         neg_reg;
    logic [CFG_BITS-1:0]          rem_reg;
    logic [SUM_BITS-1:0]          quo_reg;
    logic [MIX_STEP_BITS-1:0]     step_reg;
    logic                         done_reg;
    logic signed [SAMPLE_BITS-1:0] mono_reg;
    logic [MAG_BITS-1:0]          mag_reg;

    logic [CFG_BITS-1:0]          n_clamp;
    logic [SAMPLE_BITS-1:0]       head;
    logic signed [SUM_BITS-1:0]   sum_next;
    logic [SUM_BITS-1:0]          abs_sum;
    logic [CFG_BITS:0]            trial;
    logic                         ge;
    logic [CFG_BITS-1:0]          rem_next;
    logic [SUM_BITS-1:0]          quo_next;

    always_comb
    begin
        n_clamp  = (channel_count > CFG_BITS'(MAX_CHANNELS)) ? CFG_BITS'(MAX_CHANNELS)
                                                            : channel_count;
        head     = frame_sh_reg[0];
        sum_next = sum_reg + {{(SUM_BITS-SAMPLE_BITS){head[SAMPLE_BITS-1]}}, head};
        abs_sum  = sum_next[SUM_BITS-1] ? (~sum_next + 1'b1) : sum_next;
        trial    = {rem_reg, quo_reg[SUM_BITS-1]};
        ge       = (trial >= {1'b0, n_reg});
        rem_next = ge ? CFG_BITS'(trial - {1'b0, n_reg}) : CFG_BITS'(trial);
        quo_next = {quo_reg[SUM_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= M_IDLE;
            frame_sh_reg <= '0;
            left_reg     <= '0;
            n_reg        <= '0;
            sum_reg      <= '0;
            neg_reg      <= 1'b0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            step_reg     <= '0;
            done_reg     <= 1'b0;
            mono_reg     <= '0;
            mag_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        if (n_clamp == '0)
                        begin
                            mono_reg <= '0;
                            mag_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            frame_sh_reg <= frame;
                            left_reg     <= n_clamp;
                            n_reg        <= n_clamp;
                            sum_reg      <= '0;
                            state_reg    <= M_ACC;
                        end
                    end
                end
                M_ACC:
                begin
                    sum_reg      <= sum_next;
                    frame_sh_reg <= frame_sh_reg >> SAMPLE_BITS;
                    left_reg     <= left_reg - 1'b1;
                    if (left_reg == CFG_BITS'(1))
                    begin
                        neg_reg   <= sum_next[SUM_BITS-1];
                        quo_reg   <= abs_sum;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= M_DIV;
                    end
                end
                M_DIV:
                begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == MIX_STEP_BITS'(SUM_BITS - 1))
                    begin
                        mag_reg   <= quo_next[MAG_BITS-1:0];
                        mono_reg  <= neg_reg ? -quo_next[SAMPLE_BITS-1:0]
                                             : quo_next[SAMPLE_BITS-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign stat.done = done_reg;
    assign stat.mono = mono_reg;
    assign stat.mag  = mag_reg;

endmodule

// File: rtl/mmlm_mean_div.sv
// Bit-serial restoring divide of the square sum by the frame count
module mmlm_mean_div
    import mmlm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SQ_SUM_BITS-1:0] dividend,
    input  logic [TALLY_BITS-1:0]  divisor,
    output div_stat_t              stat
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_STEP_BITS-1:0] step_reg;
    logic [TALLY_BITS-1:0]    dvs_reg;
    logic [TALLY_BITS-1:0]    rem_reg;
    logic [SQ_SUM_BITS-1:0]   quo_reg;

    logic [TALLY_BITS:0]      trial;
    logic                     ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SQ_SUM_BITS-1]};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? TALLY_BITS'(trial - {1'b0, dvs_reg}) : TALLY_BITS'(trial);
                quo_reg  <= {quo_reg[SQ_SUM_BITS-2:0], ge};
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_STEP_BITS'(SQ_SUM_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg[MEAN_BITS-1:0];

endmodule

// File: rtl/mmlm_isqrt.sv
// Digit-serial integer square root, two radicand bits per step
module mmlm_isqrt
    import mmlm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MEAN_BITS-1:0] radicand,
    output sqrt_stat_t           stat
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [ROOT_STEP_BITS-1:0] step_reg;
    logic [MEAN_BITS-1:0]      rad_sh_reg;
    logic [ROOT_REM_BITS-1:0]  rem_reg;
    logic [ROOT_BITS-1:0]      root_reg;

    logic [ROOT_REM_BITS-1:0]  rem_sh;
    logic [ROOT_REM_BITS-1:0]  trial;
    logic                      ge;

    always_comb
    begin
        rem_sh = {rem_reg[ROOT_REM_BITS-3:0], rad_sh_reg[MEAN_BITS-1:MEAN_BITS-2]};
        trial  = ROOT_REM_BITS'({root_reg, 2'b01});
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
            rad_sh_reg <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg   <= 1'b1;
                step_reg   <= '0;
                rad_sh_reg <= radicand;
                rem_reg    <= '0;
                root_reg   <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg    <= ge ? (rem_sh - trial) : rem_sh;
                root_reg   <= {root_reg[ROOT_BITS-2:0], ge};
                rad_sh_reg <= rad_sh_reg << 2;
                step_reg   <= step_reg + 1'b1;
                if (step_reg == ROOT_STEP_BITS'(ROOT_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.root = root_reg;

endmodule

// File: rtl/mono_mix_level_meter_unit.sv
// Top level of the mono mix level meter: sequencer, block state and output register
// Ordinary frame: the result is set by the channel-serial sum over the n active channels,
// the 19-step mix divide and the 16-step square.
// Last frame of a block: the 43-step mean divide and 16-step root follow.
// One frame in work at a time; the next is accepted while a result waits in the output register.
// Reset (rst_n low, asynchronous): block state cleared, no result pending, channel count 1.
`include "mono_mix_level_meter_unit_assert.svh"

module mono_mix_level_meter_unit
    import mmlm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_BITS-1:0]           cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0] sample_ch1,
    input  logic signed [SAMPLE_BITS-1:0] sample_ch2,
    input  logic signed [SAMPLE_BITS-1:0] sample_ch3,
    input  logic signed [SAMPLE_BITS-1:0] sample_ch4,
    input  logic signed [SAMPLE_BITS-1:0] sample_ch5,
    input  logic signed [SAMPLE_BITS-1:0] sample_ch6,
    input  logic signed [SAMPLE_BITS-1:0] sample_ch7,
    input  logic                          last_of_block,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] mono_sample,
    output logic                          level_valid,
    output logic [MAG_BITS-1:0]           block_peak,
    output logic [ROOT_BITS-1:0]          block_rms,
    output logic                          block_too_long
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_SQ,
        S_DIV,
        S_SQRT,
        S_FIN
    } top_state_t;

    top_state_t                    state_reg;
    logic [CFG_BITS-1:0]           channel_count_reg;
    logic                          last_reg;
    logic [MAG_BITS-1:0]           peak_reg;
    logic [SQ_SUM_BITS-1:0]        sq_sum_reg;
    logic [TALLY_BITS-1:0]         tally_reg;
    logic                          over_reg;
    logic [MAG_BITS-1:0]           mag_sh_reg;
    logic [ADDEND_BITS-1:0]        addend_reg;
    logic [SQ_STEP_BITS-1:0]       sq_cnt_reg;
    logic                          div_start_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] mono_out_reg;
    logic                          level_reg;
    logic [MAG_BITS-1:0]           peak_out_reg;
    logic [ROOT_BITS-1:0]          rms_out_reg;
    logic                          too_long_reg;

    logic [SQ_SUM_BITS-1:0]        sq_sum_next;
    frame_t                        frame;
    logic                          accept;
    mix_stat_t                     mix_stat;
    div_stat_t                     div_stat;
    sqrt_stat_t                    sqrt_stat;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign frame[0] = sample_ch0;
    assign frame[1] = sample_ch1;
    assign frame[2] = sample_ch2;
    assign frame[3] = sample_ch3;
    assign frame[4] = sample_ch4;
    assign frame[5] = sample_ch5;
    assign frame[6] = sample_ch6;
    assign frame[7] = sample_ch7;

    assign sq_sum_next = mag_sh_reg[0] ? (sq_sum_reg + SQ_SUM_BITS'(addend_reg)) : sq_sum_reg;

    mmlm_mix u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .frame         (frame),
        .channel_count (channel_count_reg),
        .stat          (mix_stat)
    );

    mmlm_mean_div u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (sq_sum_reg),
        .divisor  (tally_reg),
        .stat     (div_stat)
    );

    mmlm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_stat.done),
        .radicand (div_stat.quotient),
        .stat     (sqrt_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            channel_count_reg <= CH_RESET;
            last_reg          <= 1'b0;
            peak_reg          <= '0;
            sq_sum_reg        <= '0;
            tally_reg         <= '0;
            over_reg          <= 1'b0;
            mag_sh_reg        <= '0;
            addend_reg        <= '0;
            sq_cnt_reg        <= '0;
            div_start_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            mono_out_reg      <= '0;
            level_reg         <= 1'b0;
            peak_out_reg      <= '0;
            rms_out_reg       <= '0;
            too_long_reg      <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (cfg_we)
            begin
                channel_count_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg  <= last_of_block;
                        state_reg <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    if (mix_stat.done)
                    begin
                        if (mix_stat.mag > peak_reg)
                        begin
                            peak_reg <= mix_stat.mag;
                        end
                        if (tally_reg >= TALLY_BITS'(MAX_BLOCK))
                        begin
                            over_reg <= 1'b1;
                            if (last_reg)
                            begin
                                div_start_reg <= 1'b1;
                                state_reg     <= S_DIV;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        else
                        begin
                            tally_reg  <= tally_reg + 1'b1;
                            mag_sh_reg <= mix_stat.mag;
                            addend_reg <= ADDEND_BITS'(mix_stat.mag);
                            sq_cnt_reg <= '0;
                            state_reg  <= S_SQ;
                        end
                    end
                end
                S_SQ:
                begin
                    sq_sum_reg <= sq_sum_next;
                    mag_sh_reg <= mag_sh_reg >> 1;
                    addend_reg <= addend_reg << 1;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == SQ_STEP_BITS'(MAG_BITS - 1))
                    begin
                        if (last_reg)
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_stat.done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        mono_out_reg  <= mix_stat.mono;
                        level_reg     <= last_reg;
                        peak_out_reg  <= last_reg ? peak_reg : '0;
                        rms_out_reg   <= last_reg ? sqrt_stat.root : '0;
                        too_long_reg  <= last_reg && over_reg;
                        if (last_reg)
                        begin
                            peak_reg   <= '0;
                            sq_sum_reg <= '0;
                            tally_reg  <= '0;
                            over_reg   <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign mono_sample    = mono_out_reg;
    assign level_valid    = level_reg;
    assign block_peak     = peak_out_reg;
    assign block_rms      = rms_out_reg;
    assign block_too_long = too_long_reg;

    `MMLM_ASSERT(a_accept_busy, (in_valid && in_ready) |=> !in_ready, "accepted a beat while busy")
    `MMLM_ASSERT(a_tally_cap, tally_reg <= TALLY_BITS'(MAX_BLOCK), "frame count past block limit")
    `MMLM_ASSERT(a_over_full, over_reg |-> (tally_reg == TALLY_BITS'(MAX_BLOCK)), "overlength without full count")
    `MMLM_ASSERT_ALWAYS(a_level_fields, (out_valid && !level_valid) |-> (block_peak == '0 && block_rms == '0 && !block_too_long), "level fields set on a plain beat")

endmodule
